@@ rtl/core/pqe_pkg.sv @@
`default_nettype none
package pqe_pkg;
  localparam int CENT_AW = 16;
  localparam int ACC_W = 40;

  typedef enum logic [1:0] {
    CFG_SUBSPACE_COUNT = 2'd0,
    CFG_CENTROID_COUNT = 2'd1,
    CFG_SUBSPACE_DIM   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  book_subspace;
    logic [7:0]  book_centroid;
    logic [3:0]  book_component;
    logic signed [15:0] book_value;
    logic signed [15:0] element_value;
    logic        element_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] code;
    logic [3:0] code_subspace;
    logic       last;
    logic       length_error;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic       clear_best;
    logic       clear_acc;
    logic       mac_en;
    logic       compare;
    logic [7:0] centroid;
    logic [3:0] component;
    logic [3:0] subspace;
  } dp_cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/product_quantization_encoder.sv @@
// A code word is presented once the element that ends a subspace is accepted and the
// search finishes; each centroid runs its dim components through the MAC, then drains.
// A last element that finishes no subspace gives its word the next cycle.
// Throughput: one search at a time; input is stalled while it runs or a word waits.
// Reset (rst, synchronous, active high) clears positions, flags and registers to
// subspace_count 1, centroid_count 256, subspace_dim 1; the codebook is not cleared.
`default_nettype none
module product_quantization_encoder (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire pqe_pkg::in_word_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output pqe_pkg::out_word_t out_data,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  import pqe_pkg::*;

  logic [4:0] subspace_count, subspace_dim;
  logic [8:0] centroid_count;
  logic buf_we, book_we;
  logic [3:0] buf_addr;
  dp_cmd_t cmd;
  logic [7:0] best_code;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      subspace_count <= 5'd1;
      centroid_count <= 9'd256;
      subspace_dim <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SUBSPACE_COUNT: subspace_count <= cfg_data[4:0];
        CFG_CENTROID_COUNT: centroid_count <= cfg_data;
        CFG_SUBSPACE_DIM:   subspace_dim <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  pqe_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .subspace_count(subspace_count), .centroid_count(centroid_count),
    .subspace_dim(subspace_dim), .buf_we(buf_we), .buf_addr(buf_addr),
    .book_we(book_we), .cmd(cmd), .best_code(best_code)
  );

  pqe_datapath u_dp (
    .clk(clk), .buf_we(buf_we), .buf_addr(buf_addr), .buf_data(in_data.element_value),
    .book_we(book_we),
    .book_addr({in_data.book_subspace, in_data.book_centroid, in_data.book_component}),
    .book_data(in_data.book_value), .cmd(cmd), .best_code(best_code)
  );
endmodule
`default_nettype wire

@@ rtl/core/pqe_ram.sv @@
`default_nettype none
module pqe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/pqe_datapath.sv @@
`default_nettype none
module pqe_datapath (
  input  wire logic clk,
  input  wire logic buf_we,
  input  wire logic [3:0] buf_addr,
  input  wire logic signed [15:0] buf_data,
  input  wire logic book_we,
  input  wire logic [15:0] book_addr,
  input  wire logic signed [15:0] book_data,
  input  wire pqe_pkg::dp_cmd_t cmd,
  output logic [7:0] best_code
);
  import pqe_pkg::*;

  logic [15:0] buf_q [16];
  logic [15:0] cent_q;
  logic signed [15:0] elem_q;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic [33:0] sq;
  logic [ACC_W:0] acc_sum;
  logic [ACC_W-1:0] acc, best_dist;
  logic mac_d1, mac_d2;
  logic [7:0] cent_d1, cent_d2;

  pqe_ram #(.WIDTH(16), .DEPTH(1 << CENT_AW)) u_book (
    .clk(clk), .we(book_we), .waddr(book_addr), .wdata(book_data),
    .raddr({cmd.subspace, cmd.centroid, cmd.component}), .rdata(cent_q)
  );

  // Subvector buffer write and element read aligned with the memory read.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_q[buf_addr] <= buf_data;
    end
    elem_q <= buf_q[cmd.component];
  end

  // Stage 1: difference and square into sq; stage 2: accumulate.
  assign diff = 17'(elem_q) - 17'($signed(cent_q));
  assign prod = diff * diff;
  always_ff @(posedge clk) begin
    mac_d1 <= cmd.mac_en;
    mac_d2 <= mac_d1;
    cent_d1 <= cmd.centroid;
    cent_d2 <= cent_d1;
    sq <= prod;
  end

  assign acc_sum = {1'b0, acc} + (ACC_W + 1)'(sq);
  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc <= '0;
    end else if (mac_d2) begin
      acc <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    end
    if (cmd.clear_best) begin
      best_dist <= '1;
      best_code <= '0;
    end else if (cmd.compare && (cent_d2 == 8'd0 || acc < best_dist)) begin
      best_dist <= acc;
      best_code <= cent_d2;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/pqe_control.sv @@
`default_nettype none
module pqe_control (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire pqe_pkg::in_word_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output pqe_pkg::out_word_t out_data,
  input  wire logic [4:0] subspace_count,
  input  wire logic [8:0] centroid_count,
  input  wire logic [4:0] subspace_dim,
  output logic buf_we,
  output logic [3:0] buf_addr,
  output logic book_we,
  output pqe_pkg::dp_cmd_t cmd,
  input  wire logic [7:0] best_code
);
  import pqe_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;
  state_t state;

  logic [4:0] m, dim;
  logic [8:0] ncent;
  logic [4:0] sub_pos;
  logic [3:0] comp_pos;
  logic overrun;
  logic [7:0] cent;
  logic [3:0] comp;
  logic [2:0] drain;
  logic pend_last, pend_err;
  logic [3:0] pend_sub;
  logic accept, ov_now;
  logic [4:0] pos_inc;
  logic last_comp, last_cent;
  logic search_start, bare_last, out_load;
  out_word_t out_q;
  logic code_sel;

  assign m = (subspace_count == 5'd0) ? 5'd1 :
             (subspace_count > 5'd16 ? 5'd16 : subspace_count);
  assign dim = (subspace_dim == 5'd0) ? 5'd1 :
               (subspace_dim > 5'd16 ? 5'd16 : subspace_dim);
  assign ncent = (centroid_count < 9'd2) ? 9'd2 :
                 (centroid_count > 9'd256 ? 9'd256 : centroid_count);

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;
  assign ov_now = overrun || (sub_pos >= m);
  assign pos_inc = {1'b0, comp_pos} + 5'd1;
  assign book_we = accept && !in_data.kind;
  assign buf_we = accept && in_data.kind && !ov_now;
  assign buf_addr = comp_pos;
  assign last_comp = ({1'b0, comp} == dim - 5'd1);
  assign last_cent = ({1'b0, cent} == ncent - 9'd1);

  // An element that completes a subspace starts a search; a last element otherwise
  // gives a bare length error.
  assign search_start = (state == ST_IDLE) && accept && in_data.kind && !ov_now &&
                        (pos_inc >= dim);
  assign bare_last = (state == ST_IDLE) && accept && in_data.kind && !search_start &&
                     in_data.element_last;
  assign out_load = bare_last || (state == ST_DRAIN && drain == 3'd0 && last_cent);

  always_comb begin
    cmd.centroid = cent;
    cmd.component = comp;
    cmd.subspace = pend_sub;
    cmd.mac_en = (state == ST_RUN);
    cmd.clear_acc = (state == ST_IDLE) || (state == ST_DRAIN && drain == 3'd0);
    cmd.clear_best = search_start;
    cmd.compare = (state == ST_DRAIN && drain == 3'd0);
  end

  // A search word's code comes straight from the datapath, which holds it until the next search.
  assign out_data = '{code: code_sel ? best_code : out_q.code,
                      code_subspace: out_q.code_subspace, last: out_q.last,
                      length_error: out_q.length_error};

  // Sequencer: buffer elements while idle; walk centroids by components, then wait for the MAC pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sub_pos <= '0;
      comp_pos <= '0;
      overrun <= 1'b0;
      out_valid <= 1'b0;
      code_sel <= 1'b0;
      cent <= '0;
      comp <= '0;
      drain <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_data.kind) begin
            if (search_start) begin
              pend_sub <= sub_pos[3:0];
              pend_last <= in_data.element_last;
              pend_err <= in_data.element_last && (sub_pos + 5'd1 != m);
              comp_pos <= '0;
              cent <= '0;
              comp <= '0;
              state <= ST_RUN;
              if (in_data.element_last) begin
                sub_pos <= '0;
                overrun <= 1'b0;
              end else if (sub_pos + 5'd1 >= m) begin
                sub_pos <= '0;
                overrun <= 1'b1;
              end else begin
                sub_pos <= sub_pos + 5'd1;
              end
            end else if (in_data.element_last) begin
              out_q <= '{code: 8'd0, code_subspace: 4'd0, last: 1'b1,
                         length_error: 1'b1};
              code_sel <= 1'b0;
              sub_pos <= '0;
              comp_pos <= '0;
              overrun <= 1'b0;
            end else begin
              overrun <= ov_now;
              if (!ov_now) begin
                comp_pos <= pos_inc[3:0];
              end
            end
          end
        end
        ST_RUN: begin
          if (last_comp) begin
            comp <= '0;
            drain <= 3'd3;
            state <= ST_DRAIN;
          end else begin
            comp <= comp + 4'd1;
          end
        end
        ST_DRAIN: begin
          if (drain == 3'd0) begin
            if (last_cent) begin
              cent <= '0;
              out_q <= '{code: 8'd0, code_subspace: pend_sub, last: pend_last,
                         length_error: pend_err};
              code_sel <= 1'b1;
              state <= ST_IDLE;
            end else begin
              cent <= cent + 8'd1;
              state <= ST_RUN;
            end
          end else begin
            drain <= drain - 3'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state != ST_IDLE) |-> in_stall)
    else $error("input taken during search");
  assert property (@(posedge clk) disable iff (rst)
                   buf_we |-> (comp_pos < dim[3:0] || dim == 5'd16))
    else $error("buffer write past subspace");
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed");
endmodule
`default_nettype wire
